// File: hw/rtl/segint_pkg.sv
// Shared constants and types for the segment intersection test unit.
`default_nettype none

package segint_pkg;

  // Each coordinate travels in a 32-bit lane of the input word.
  localparam int unsigned FIELD_BITS      = 32;
  localparam int unsigned NUM_FIELDS      = 8;
  localparam int unsigned IN_DATA_BITS    = FIELD_BITS * NUM_FIELDS;
  localparam int unsigned OUT_DATA_BITS   = 8;
  localparam int unsigned COORD_BITS_DEF  = 32;

  // Lane positions of the coordinates in the input word.
  localparam int unsigned F_A_START_X = 0;
  localparam int unsigned F_A_START_Y = 1;
  localparam int unsigned F_A_END_X   = 2;
  localparam int unsigned F_A_END_Y   = 3;
  localparam int unsigned F_B_START_X = 4;
  localparam int unsigned F_B_START_Y = 5;
  localparam int unsigned F_B_END_X   = 6;
  localparam int unsigned F_B_END_Y   = 7;

  // Load enables of the two pipeline stages inside a cross-product unit.
  typedef struct packed {
    logic mul_en;
    logic sgn_en;
  } segint_ctl_t;

  // Sign of a cross product: negative, zero, or (neither) positive.
  typedef struct packed {
    logic neg;
    logic zero;
  } segint_sign_t;

  // True when v lies between the two ends, whichever order they come in.
  function automatic logic between(input logic signed [FIELD_BITS-1:0] end_a,
                                   input logic signed [FIELD_BITS-1:0] end_b,
                                   input logic signed [FIELD_BITS-1:0] v);
    logic fwd;
    logic rev;
    fwd = (v >= end_a) && (v <= end_b);
    rev = (v >= end_b) && (v <= end_a);
    return fwd || rev;
  endfunction

  // Both signs strictly positive or both strictly negative.
  function automatic logic same_strict(input segint_sign_t s_a,
                                       input segint_sign_t s_b);
    logic both_pos;
    logic both_neg;
    both_pos = !s_a.zero && !s_a.neg && !s_b.zero && !s_b.neg;
    both_neg = s_a.neg && s_b.neg;
    return both_pos || both_neg;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/segment_intersection_test_unit.sv
// Top level: four-stage pipelined test of whether two plane segments meet.
// Flow: a pair is registered in stages 1 to 4 in turn; m_axis_tvalid marks stage 4.
// Throughput: one segment pair per cycle; an output stall holds full stages, bubbles close.
// Stages: differences and box checks, products, product difference signs, verdict.
// Reset: rst_ni is asynchronous and active low and clears the stage valid bits only.
`default_nettype none

module segment_intersection_test_unit
  import segint_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  // From bit 0 up, 32 bits each: seg_a_start_x, seg_a_start_y, seg_a_end_x,
  // seg_a_end_y, seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y.
  input  wire [IN_DATA_BITS-1:0]   s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  // Bit 0: segments_meet; bits 7:1 are zero.
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] crd [NUM_FIELDS];
  logic signed [FIELD_BITS-1:0] crd_w [NUM_FIELDS];

  for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_crd
    assign crd[i]   = s_axis_tdata[i*FIELD_BITS +: COORD_BITS];
    assign crd_w[i] = FIELD_BITS'(crd[i]);
  end

  // Stage valid bits and the ready chain.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: coordinate differences and the collinear overlap check.
  logic signed [DIFF_W-1:0] dax_q, day_q, dbx_q, dby_q;
  logic signed [DIFF_W-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
  logic signed [DIFF_W-1:0] f1x_q, f1y_q, f2x_q, f2y_q;
  logic box_d, box1_q, box2_q, box3_q;
  logic ld1;

  assign ld1 = rdy1 && s_axis_tvalid;

  // Used only when all four orientations are zero, so a box test is enough.
  always_comb begin
    box_d =
      (between(crd_w[F_A_START_X], crd_w[F_A_END_X], crd_w[F_B_START_X]) &&
       between(crd_w[F_A_START_Y], crd_w[F_A_END_Y], crd_w[F_B_START_Y])) ||
      (between(crd_w[F_A_START_X], crd_w[F_A_END_X], crd_w[F_B_END_X]) &&
       between(crd_w[F_A_START_Y], crd_w[F_A_END_Y], crd_w[F_B_END_Y])) ||
      (between(crd_w[F_B_START_X], crd_w[F_B_END_X], crd_w[F_A_START_X]) &&
       between(crd_w[F_B_START_Y], crd_w[F_B_END_Y], crd_w[F_A_START_Y])) ||
      (between(crd_w[F_B_START_X], crd_w[F_B_END_X], crd_w[F_A_END_X]) &&
       between(crd_w[F_B_START_Y], crd_w[F_B_END_Y], crd_w[F_A_END_Y]));
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      dax_q  <= DIFF_W'(crd[F_A_END_X])   - DIFF_W'(crd[F_A_START_X]);
      day_q  <= DIFF_W'(crd[F_A_END_Y])   - DIFF_W'(crd[F_A_START_Y]);
      dbx_q  <= DIFF_W'(crd[F_B_END_X])   - DIFF_W'(crd[F_B_START_X]);
      dby_q  <= DIFF_W'(crd[F_B_END_Y])   - DIFF_W'(crd[F_B_START_Y]);
      e1x_q  <= DIFF_W'(crd[F_B_START_X]) - DIFF_W'(crd[F_A_START_X]);
      e1y_q  <= DIFF_W'(crd[F_B_START_Y]) - DIFF_W'(crd[F_A_START_Y]);
      e2x_q  <= DIFF_W'(crd[F_B_END_X])   - DIFF_W'(crd[F_A_START_X]);
      e2y_q  <= DIFF_W'(crd[F_B_END_Y])   - DIFF_W'(crd[F_A_START_Y]);
      f1x_q  <= DIFF_W'(crd[F_A_START_X]) - DIFF_W'(crd[F_B_START_X]);
      f1y_q  <= DIFF_W'(crd[F_A_START_Y]) - DIFF_W'(crd[F_B_START_Y]);
      f2x_q  <= DIFF_W'(crd[F_A_END_X])   - DIFF_W'(crd[F_B_START_X]);
      f2y_q  <= DIFF_W'(crd[F_A_END_Y])   - DIFF_W'(crd[F_B_START_Y]);
      box1_q <= box_d;
    end
  end

  // Stages 2 and 3 live in the cross-product units.
  segint_ctl_t  cross_ctl;
  segint_sign_t sgn1, sgn2, sgn3, sgn4;

  always_comb begin
    cross_ctl.mul_en = rdy2 && v1_q;
    cross_ctl.sgn_en = rdy3 && v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (cross_ctl.mul_en) box2_q <= box1_q;
    if (cross_ctl.sgn_en) box3_q <= box2_q;
  end

  segint_cross #(.COORD_BITS(COORD_BITS)) u_cross_b_start (
    .clk_i, .rst_ni, .ctl_i(cross_ctl),
    .a_i(dax_q), .b_i(e1y_q), .c_i(day_q), .d_i(e1x_q), .sign_o(sgn1)
  );

  segint_cross #(.COORD_BITS(COORD_BITS)) u_cross_b_end (
    .clk_i, .rst_ni, .ctl_i(cross_ctl),
    .a_i(dax_q), .b_i(e2y_q), .c_i(day_q), .d_i(e2x_q), .sign_o(sgn2)
  );

  segint_cross #(.COORD_BITS(COORD_BITS)) u_cross_a_start (
    .clk_i, .rst_ni, .ctl_i(cross_ctl),
    .a_i(dbx_q), .b_i(f1y_q), .c_i(dby_q), .d_i(f1x_q), .sign_o(sgn3)
  );

  segint_cross #(.COORD_BITS(COORD_BITS)) u_cross_a_end (
    .clk_i, .rst_ni, .ctl_i(cross_ctl),
    .a_i(dbx_q), .b_i(f2y_q), .c_i(dby_q), .d_i(f2x_q), .sign_o(sgn4)
  );

  // Stage 4: verdict into the output register.
  logic collinear, meet_d, meet_q, ld4;

  assign collinear = sgn1.zero && sgn2.zero && sgn3.zero && sgn4.zero;
  assign meet_d    = collinear ? box3_q
                               : (!same_strict(sgn1, sgn2) && !same_strict(sgn3, sgn4));
  assign ld4       = rdy4 && v3_q;

  always_ff @(posedge clk_i) begin
    if (ld4) meet_q <= meet_d;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS - 1){1'b0}}, meet_q};

  // An empty output register must let the whole pipeline move.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  // A stalled first stage keeps its differences.
  a_stage1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q && $stable(dax_q) && $stable(e1y_q) && $stable(box1_q))
    else $error("first stage changed while stalled");

  // A stalled sign stage keeps its signs and overlap flag.
  a_stage3_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy4 |=> v3_q && $stable(sgn1) && $stable(sgn4) && $stable(box3_q))
    else $error("sign stage changed while stalled");

  // A held result bit only changes when a new word enters the output register.
  a_out_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !$past(ld4) |-> $stable(meet_q))
    else $error("result changed without a load");

endmodule

`default_nettype wire

// File: hw/rtl/segint_cross.sv
// Two-stage unit giving the exact sign of a*b - c*d.
`default_nettype none

module segint_cross
  import segint_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire segint_ctl_t               ctl_i,
  input  wire logic signed [COORD_BITS:0] a_i,
  input  wire logic signed [COORD_BITS:0] b_i,
  input  wire logic signed [COORD_BITS:0] c_i,
  input  wire logic signed [COORD_BITS:0] d_i,
  output segint_sign_t                   sign_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;

  logic signed [PROD_W-1:0] prod_p_d, prod_p_q;
  logic signed [PROD_W-1:0] prod_q_d, prod_q_q;
  logic signed [PROD_W:0]   delta;
  segint_sign_t             sign_d, sign_q;

  assign prod_p_d = PROD_W'(a_i) * PROD_W'(b_i);
  assign prod_q_d = PROD_W'(c_i) * PROD_W'(d_i);

  // One guard bit keeps the difference of the two products exact.
  assign delta = (PROD_W + 1)'(prod_p_q) - (PROD_W + 1)'(prod_q_q);

  always_comb begin
    sign_d.neg  = delta[PROD_W];
    sign_d.zero = (delta == '0);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_p_q <= prod_p_d;
      prod_q_q <= prod_q_d;
    end
    if (ctl_i.sgn_en) begin
      sign_q <= sign_d;
    end
  end

  assign sign_o = sign_q;

  // rst_ni is unused here: the unit holds payload only.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

`default_nettype wire
